// ===== design/iucc_pkg.sv =====
// Shared types, constants and a helper function of the IPv4/UDP checksum checker.
package iucc_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int          LHB_W     = 6;
    localparam logic [5:0]  LHB_RESET = 6'd14;
    localparam int          ADDR_W    = 3;
    localparam int          DATA_W    = 32;
    localparam logic        REG_LINK_HDR_IDX = 1'b0;

    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam int          IP_SUM_LO_BYTE  = 11;
    localparam int          IP_ADDR_FIRST   = 12;
    localparam int          IP_ADDR_END     = 20;
    localparam int          UDP_HDR_BYTES   = 8;
    localparam int          UDP_LEN_LO_BYTE = 5;
    localparam int          UDP_SUM_LO_BYTE = 7;
    localparam logic [15:0] UDP_PROTO       = 16'd17;
    localparam int          NEED_W          = 17;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_IP_ADD,
        OP_IP_UDP_ADD,
        OP_UDP_ADD,
        OP_UDP_ADD2,
        OP_STORE_IP,
        OP_STORE_UDP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] word;
        logic        last;
        logic        short_frame;
    } q_entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

// ===== design/iucc_front.sv =====
// Front part: tracks the frame position and classifies each byte into a sum operation.
module iucc_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               frame_byte,
    input  logic                     end_of_frame,
    input  logic [iucc_pkg::LHB_W-1:0] link_header_bytes,
    output iucc_pkg::q_entry_t       push_entry
);

    logic [iucc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [3:0]                 hw_reg, hw_next;
    logic [15:0]                len_reg, len_next;
    logic [7:0]                 hold_reg, hold_next;

    logic                           active;
    logic                           in_span;
    logic [iucc_pkg::POS_W-1:0]     rel;
    logic [iucc_pkg::POS_W-1:0]     rel_u;
    logic [iucc_pkg::POS_W-1:0]     rel_p;
    logic [5:0]                     hdr_bytes;
    logic [15:0]                    plen;
    logic [15:0]                    word;
    logic                           payload_hit;
    logic                           payload_last;
    logic [15:0]                    len_floor;
    logic [iucc_pkg::NEED_W-1:0]    need;
    iucc_pkg::op_t                  op;
    logic [15:0]                    word_out;

    always_comb
    begin
        active    = pos_reg < iucc_pkg::POS_W'(iucc_pkg::MAX_FRAME_BYTES);
        in_span   = pos_reg >= iucc_pkg::POS_W'(link_header_bytes);
        rel       = pos_reg - iucc_pkg::POS_W'(link_header_bytes);
        hdr_bytes = {hw_reg, 2'b00};
        rel_u     = rel - iucc_pkg::POS_W'(hdr_bytes);
        rel_p     = rel_u - iucc_pkg::POS_W'(iucc_pkg::UDP_HDR_BYTES);
        plen      = (len_reg >= 16'(iucc_pkg::UDP_HDR_BYTES))
                    ? len_reg - 16'(iucc_pkg::UDP_HDR_BYTES) : 16'd0;
        word      = {hold_reg, frame_byte};
        payload_hit  = 16'(rel_p) < plen;
        payload_last = (16'(rel_p) + 16'd1) == plen;

        op        = iucc_pkg::OP_NONE;
        word_out  = word;
        hold_next = hold_reg;
        hw_next   = hw_reg;
        len_next  = len_reg;

        if (active && in_span)
        begin
            if (rel < iucc_pkg::POS_W'(hdr_bytes))
            begin
                if (rel == '0)
                begin
                    hw_next = (frame_byte[3:0] < iucc_pkg::IHL_MIN) ? iucc_pkg::IHL_MIN
                                                                   : frame_byte[3:0];
                end
                if (!rel[0])
                begin
                    hold_next = frame_byte;
                end
                else if (rel == iucc_pkg::POS_W'(iucc_pkg::IP_SUM_LO_BYTE))
                begin
                    op = iucc_pkg::OP_STORE_IP;
                end
                else if (rel >= iucc_pkg::POS_W'(iucc_pkg::IP_ADDR_FIRST) &&
                         rel <  iucc_pkg::POS_W'(iucc_pkg::IP_ADDR_END))
                begin
                    op = iucc_pkg::OP_IP_UDP_ADD;
                end
                else
                begin
                    op = iucc_pkg::OP_IP_ADD;
                end
            end
            else if (rel_u < iucc_pkg::POS_W'(iucc_pkg::UDP_HDR_BYTES))
            begin
                if (!rel_u[0])
                begin
                    hold_next = frame_byte;
                end
                else if (rel_u == iucc_pkg::POS_W'(iucc_pkg::UDP_LEN_LO_BYTE))
                begin
                    len_next = word;
                    op       = iucc_pkg::OP_UDP_ADD2;
                end
                else if (rel_u == iucc_pkg::POS_W'(iucc_pkg::UDP_SUM_LO_BYTE))
                begin
                    op = iucc_pkg::OP_STORE_UDP;
                end
                else
                begin
                    op = iucc_pkg::OP_UDP_ADD;
                end
            end
            else if (payload_hit)
            begin
                if (!rel_p[0])
                begin
                    hold_next = frame_byte;
                    if (payload_last)
                    begin
                        op       = iucc_pkg::OP_UDP_ADD;
                        word_out = {frame_byte, 8'h00};
                    end
                end
                else
                begin
                    op = iucc_pkg::OP_UDP_ADD;
                end
            end
        end

        pos_next  = active ? pos_reg + iucc_pkg::POS_W'(1) : pos_reg;
        len_floor = (len_next >= 16'(iucc_pkg::UDP_HDR_BYTES))
                    ? len_next : 16'(iucc_pkg::UDP_HDR_BYTES);
        need      = iucc_pkg::NEED_W'(link_header_bytes)
                  + iucc_pkg::NEED_W'({hw_next, 2'b00})
                  + iucc_pkg::NEED_W'(len_floor);

        push_entry.op          = op;
        push_entry.word        = word_out;
        push_entry.last        = end_of_frame;
        push_entry.short_frame = iucc_pkg::NEED_W'(pos_next) < need;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hw_reg   <= iucc_pkg::IHL_MIN;
            len_reg  <= '0;
            hold_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_frame)
            begin
                pos_reg  <= '0;
                hw_reg   <= iucc_pkg::IHL_MIN;
                len_reg  <= '0;
                hold_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                hw_reg   <= hw_next;
                len_reg  <= len_next;
                hold_reg <= hold_next;
            end
        end
    end

endmodule

// ===== design/iucc_queue.sv =====
// Short queue of classified byte operations between the front and back parts.
module iucc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  iucc_pkg::q_entry_t   push_entry,
    input  logic                 pop,
    output iucc_pkg::q_entry_t   head,
    output iucc_pkg::q_status_t  status
);

    iucc_pkg::q_entry_t             slot_reg [iucc_pkg::QUEUE_DEPTH];
    logic [iucc_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [iucc_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [iucc_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + iucc_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + iucc_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + iucc_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - iucc_pkg::Q_CNT_W'(1);
        end
        head         = slot_reg[rd_ptr_reg];
        status.full  = cnt_reg == iucc_pkg::Q_CNT_W'(iucc_pkg::QUEUE_DEPTH);
        status.empty = cnt_reg == '0;
        status.count = cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/iucc_back.sv =====
// Back part: folds the sums, keeps the received checksums and registers the result beat.
module iucc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  iucc_pkg::q_entry_t  head,
    input  logic                q_empty,
    input  logic                out_stall,
    output logic                pop,
    output logic                out_valid,
    output logic [15:0]         ip_sum_computed,
    output logic [15:0]         ip_sum_received,
    output logic [15:0]         udp_sum_computed,
    output logic [15:0]         udp_sum_received,
    output logic                ip_match,
    output logic                udp_match,
    output logic                frame_short
);

    logic [15:0] ip_acc_reg, ip_acc_next;
    logic [15:0] udp_acc_reg, udp_acc_next;
    logic [15:0] ip_st_reg, ip_st_next;
    logic [15:0] udp_st_reg, udp_st_next;
    logic        out_valid_reg;
    logic [15:0] ip_c_reg, ip_r_reg, udp_c_reg, udp_r_reg;
    logic        ip_m_reg, udp_m_reg, short_reg;

    logic [15:0] ip_add;
    logic [15:0] udp_add1;
    logic [15:0] udp_add2;
    logic [15:0] ip_c;
    logic [15:0] udp_c;

    always_comb
    begin
        pop      = !q_empty && (!head.last || !out_valid_reg || !out_stall);
        ip_add   = iucc_pkg::fold_add(ip_acc_reg, head.word);
        udp_add1 = iucc_pkg::fold_add(udp_acc_reg, head.word);
        udp_add2 = iucc_pkg::fold_add(udp_add1, head.word);

        ip_acc_next  = ip_acc_reg;
        udp_acc_next = udp_acc_reg;
        ip_st_next   = ip_st_reg;
        udp_st_next  = udp_st_reg;
        unique case (head.op)
            iucc_pkg::OP_NONE:
            begin
            end
            iucc_pkg::OP_IP_ADD:
            begin
                ip_acc_next = ip_add;
            end
            iucc_pkg::OP_IP_UDP_ADD:
            begin
                ip_acc_next  = ip_add;
                udp_acc_next = udp_add1;
            end
            iucc_pkg::OP_UDP_ADD:
            begin
                udp_acc_next = udp_add1;
            end
            iucc_pkg::OP_UDP_ADD2:
            begin
                udp_acc_next = udp_add2;
            end
            iucc_pkg::OP_STORE_IP:
            begin
                ip_st_next = head.word;
            end
            iucc_pkg::OP_STORE_UDP:
            begin
                udp_st_next = head.word;
            end
            default:
            begin
            end
        endcase

        ip_c  = ~ip_acc_next;
        udp_c = ~iucc_pkg::fold_add(udp_acc_next, iucc_pkg::UDP_PROTO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_acc_reg    <= '0;
            udp_acc_reg   <= '0;
            ip_st_reg     <= '0;
            udp_st_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head.last)
                begin
                    ip_acc_reg  <= '0;
                    udp_acc_reg <= '0;
                    ip_st_reg   <= '0;
                    udp_st_reg  <= '0;
                end
                else
                begin
                    ip_acc_reg  <= ip_acc_next;
                    udp_acc_reg <= udp_acc_next;
                    ip_st_reg   <= ip_st_next;
                    udp_st_reg  <= udp_st_next;
                end
            end
            if (pop && head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            ip_c_reg  <= ip_c;
            ip_r_reg  <= ip_st_next;
            udp_c_reg <= udp_c;
            udp_r_reg <= udp_st_next;
            ip_m_reg  <= ip_c == ip_st_next;
            udp_m_reg <= udp_c == udp_st_next;
            short_reg <= head.short_frame;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ip_sum_computed  = ip_c_reg;
    assign ip_sum_received  = ip_r_reg;
    assign udp_sum_computed = udp_c_reg;
    assign udp_sum_received = udp_r_reg;
    assign ip_match         = ip_m_reg;
    assign udp_match        = udp_m_reg;
    assign frame_short      = short_reg;

endmodule

// ===== design/ipv4_udp_checksum_checker.sv =====
// Top level of the IPv4 header and UDP checksum checker.
//
// The input channel carries one frame byte per beat (frame_byte, with end_of_frame
// set on the final byte) under in_valid and in_stall. The first link_header_bytes
// bytes are skipped; the IPv4 header sum and the UDP sum with its pseudo-header are
// then folded byte pair by byte pair. The output channel gives one result beat per
// frame, on its last byte, under out_valid and out_stall.
// The block accepts one byte every cycle while the queue is not full. The final
// byte is first written into the queue; once it reaches the head of the queue,
// it is popped through the back adder into the output register.
// A four-entry queue separates the classifier from the adders, so the input is
// stalled only when that queue is full. When the receiver stalls a result beat,
// bytes of the next frame keep flowing until the next final byte reaches the head
// of the queue.
// Reset clears the frame state and sets link_header_bytes to 14. The register
// sits at APB address 0 and may be rewritten between frames or between bytes;
// a new value applies from the next byte accepted.
module ipv4_udp_checksum_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iucc_pkg::ADDR_W-1:0] paddr,
    input  logic [iucc_pkg::DATA_W-1:0] pwdata,
    output logic [iucc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  frame_byte,
    input  logic                        end_of_frame,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 ip_sum_computed,
    output logic [15:0]                 ip_sum_received,
    output logic [15:0]                 udp_sum_computed,
    output logic [15:0]                 udp_sum_received,
    output logic                        ip_match,
    output logic                        udp_match,
    output logic                        frame_short
);

    logic [iucc_pkg::LHB_W-1:0] lhb_reg;
    logic                       cfg_write;
    logic                       in_accept;
    iucc_pkg::q_entry_t         push_entry;
    iucc_pkg::q_entry_t         q_head;
    iucc_pkg::q_status_t        q_status;
    logic                       back_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == iucc_pkg::REG_LINK_HDR_IDX);
    assign prdata    = (paddr[2] == iucc_pkg::REG_LINK_HDR_IDX)
                       ? iucc_pkg::DATA_W'(lhb_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lhb_reg <= iucc_pkg::LHB_RESET;
        end
        else if (cfg_write)
        begin
            lhb_reg <= pwdata[iucc_pkg::LHB_W-1:0];
        end
    end

    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !in_stall;

    iucc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .frame_byte        (frame_byte),
        .end_of_frame      (end_of_frame),
        .link_header_bytes (lhb_reg),
        .push_entry        (push_entry)
    );

    iucc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_entry (push_entry),
        .pop        (back_pop),
        .head       (q_head),
        .status     (q_status)
    );

    iucc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (q_head),
        .q_empty          (q_status.empty),
        .out_stall        (out_stall),
        .pop              (back_pop),
        .out_valid        (out_valid),
        .ip_sum_computed  (ip_sum_computed),
        .ip_sum_received  (ip_sum_received),
        .udp_sum_computed (udp_sum_computed),
        .udp_sum_received (udp_sum_received),
        .ip_match         (ip_match),
        .udp_match        (udp_match),
        .frame_short      (frame_short)
    );

    a_last_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (back_pop && q_head.last) |-> (!out_valid || !out_stall))
        else $error("final byte left the queue while a result beat was blocked");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_pop && q_head.last))
        else $error("result beat appeared without a final byte");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !back_pop) |=> (q_status.count == $past(q_status.count) + 1))
        else $error("queue count did not follow an accepted byte");

    a_match_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ip_match == (ip_sum_computed == ip_sum_received)) &&
                       (udp_match == (udp_sum_computed == udp_sum_received))))
        else $error("match flags disagree with the reported sums");

endmodule
